>>> design/kmi_pkg.sv
// Shared constants, types and helpers of the keyframe matrix interpolator.
package kmi_pkg;

  localparam int MAX_KEYS = 16;
  localparam int KEY_W    = $clog2(MAX_KEYS);
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);
  localparam int ELEMS    = 16;
  localparam int ELEM_W   = 4;
  localparam int MADDR_W  = KEY_W + ELEM_W;
  localparam int TIME_W   = 24;
  localparam int VAL_W    = 32;
  localparam int ALPHA_W  = 17;
  localparam int DIFF_W   = TIME_W + 1;
  localparam logic [VAL_W-1:0] ONE_Q16 = 32'h0001_0000;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_LOCKED = 2'd2
  } status_t;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SRCH = 8'b0000_0010,
    S_DIV  = 8'b0000_0100,
    S_ZERO = 8'b0000_1000,
    S_RESP = 8'b0001_0000,
    S_RD   = 8'b0010_0000,
    S_MUL  = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] num;
    logic [TIME_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [ALPHA_W-1:0] alpha;
  } div_rsp_t;

  typedef struct packed {
    logic               we;
    logic [MADDR_W-1:0] addr;
    logic [VAL_W-1:0]   data;
  } mem_wr_t;

  // Diagonal positions of a row-major 4x4 matrix have equal row and column.
  function automatic logic is_diag(logic [ELEM_W-1:0] e);
    return e[1:0] == e[3:2];
  endfunction

  function automatic logic [VAL_W-1:0] ident_val(logic [ELEM_W-1:0] e);
    return is_diag(e) ? ONE_Q16 : '0;
  endfunction

endpackage

>>> design/keyframe_matrix_interpolator.sv
// Top level: keyframe table, search and command sequencer, result register.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | command, key_time, element_index, element_value
//   out_    | output    | out_valid/out_stall| result_value, result_index, last_of_run, status,
//           |           |                    | is_animated_flag, is_identity_flag
//   cfg_    | input     | cfg_valid/cfg_ready| single_key_lock
//
// A query runs the search, a divider pass when it blends, and read, multiply and emit steps
// for each of its 16 elements. A write to a new time runs the search and then zeroes the new
// matrix slot, apart from the written element.
// Reset empties the table and the lock at once; no clearing pass is needed.
// in_stall is high from an accepted command other than CMD_NONE until its last result is loaded,
// and a stalled result holds the sequencer in place.
module keyframe_matrix_interpolator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_command,
  input  logic signed [23:0]            in_key_time,
  input  logic [3:0]                    in_element_index,
  input  logic signed [31:0]            in_element_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_result_value,
  output logic [3:0]                    out_result_index,
  output logic                          out_last_of_run,
  output logic [1:0]                    out_status,
  output logic                          out_is_animated_flag,
  output logic                          out_is_identity_flag,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_single_key_lock
);

  localparam int MK = kmi_pkg::MAX_KEYS;
  localparam int KW = kmi_pkg::KEY_W;
  localparam int CW = kmi_pkg::CNT_W;
  localparam int EW = kmi_pkg::ELEM_W;
  localparam int TW = kmi_pkg::TIME_W;
  localparam int VW = kmi_pkg::VAL_W;

  kmi_pkg::state_t state_r, state_nxt;
  kmi_pkg::cmd_t   cmd_r;
  kmi_pkg::status_t status_r;

  logic signed [TW-1:0] t_r;
  logic [EW-1:0]        ei_r;
  logic [VW-1:0]        ev_r;
  logic                 lock_r;
  logic [CW-1:0]        key_cnt_r;
  logic [TW-1:0]        times_r [MK];
  logic [KW-1:0]        slots_r [MK];
  logic [kmi_pkg::ELEMS-1:0] nonid_r [MK];
  logic [CW-1:0]        pos_r;
  logic [TW-1:0]        prev_time_r;
  logic [KW-1:0]        prev_slot_r;
  logic [KW-1:0]        slot_a_r;
  logic [KW-1:0]        slot_b_r;
  logic [kmi_pkg::ALPHA_W-1:0] alpha_r;
  logic [EW-1:0]        e_r;
  logic [EW-1:0]        z_r;

  logic                 out_valid_r;
  logic [VW-1:0]        out_value_r;
  logic [EW-1:0]        out_index_r;
  logic                 out_last_r;
  logic [1:0]           out_status_r;
  logic                 out_anim_r;
  logic                 out_ident_r;

  logic [KW-1:0]        pos_idx;
  logic [TW-1:0]        cur_time;
  logic [KW-1:0]        cur_slot;
  logic                 in_range, less, found, advance, full, lock_block, blend_case;
  logic [TW:0]          num_full, den_full;
  logic                 in_acc, out_free, load_emit, load_resp;
  logic                 anim_now, ident_now;
  logic [KW-1:0]        new_slot;
  logic [VW-1:0]        blend_value;
  kmi_pkg::div_req_t    div_req;
  kmi_pkg::div_rsp_t    div_rsp;
  kmi_pkg::mem_wr_t     mem_wr;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = state_r != kmi_pkg::S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign pos_idx    = pos_r[KW-1:0];
  assign cur_time   = times_r[pos_idx];
  assign cur_slot   = slots_r[pos_idx];
  assign in_range   = pos_r < key_cnt_r;
  assign less       = $signed(cur_time) < t_r;
  assign advance    = in_range && less;
  assign found      = in_range && (cur_time == t_r);
  assign full       = key_cnt_r >= CW'(MK);
  assign lock_block = lock_r && (key_cnt_r != '0);
  assign blend_case = in_range && (pos_r != '0);
  assign new_slot   = key_cnt_r[KW-1:0];

  assign num_full = {t_r[TW-1], t_r} - {prev_time_r[TW-1], prev_time_r};
  assign den_full = {cur_time[TW-1], cur_time} - {prev_time_r[TW-1], prev_time_r};

  assign load_emit = (state_r == kmi_pkg::S_EMIT) && out_free;
  assign load_resp = (state_r == kmi_pkg::S_RESP) && out_free;

  always_comb begin
    div_req.start = (state_r == kmi_pkg::S_SRCH) && (cmd_r == kmi_pkg::CMD_QUERY) &&
                    !advance && blend_case;
    div_req.num   = num_full[TW-1:0];
    div_req.den   = den_full[TW-1:0];
  end

  always_comb begin
    mem_wr.we   = 1'b0;
    mem_wr.addr = {cur_slot, ei_r};
    mem_wr.data = ev_r;
    if ((state_r == kmi_pkg::S_SRCH) && (cmd_r == kmi_pkg::CMD_WRITE) && !advance && found) begin
      mem_wr.we = 1'b1;
    end else if (state_r == kmi_pkg::S_ZERO) begin
      mem_wr.we   = 1'b1;
      mem_wr.addr = {new_slot, z_r};
      mem_wr.data = (z_r == ei_r) ? ev_r : '0;
    end
  end

  // Flags reflect the table after the command, which is settled when results load.
  always_comb begin
    anim_now  = key_cnt_r > CW'(1);
    ident_now = 1'b1;
    for (int k = 0; k < MK; k++) begin
      if ((CW'(k) < key_cnt_r) && (|nonid_r[k])) begin
        ident_now = 1'b0;
      end
    end
  end

  kmi_alpha_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  kmi_matrix_store u_store (
    .clk         (clk),
    .wr          (mem_wr),
    .raddr_a     ({slot_a_r, e_r}),
    .raddr_b     ({slot_b_r, e_r}),
    .alpha       (alpha_r),
    .blend_value (blend_value)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kmi_pkg::S_IDLE: begin
        if (in_acc) begin
          priority case (kmi_pkg::cmd_t'(in_command))
            kmi_pkg::CMD_CLEAR: state_nxt = kmi_pkg::S_RESP;
            kmi_pkg::CMD_WRITE,
            kmi_pkg::CMD_QUERY: state_nxt = kmi_pkg::S_SRCH;
            default:            state_nxt = kmi_pkg::S_IDLE;
          endcase
        end
      end
      kmi_pkg::S_SRCH: begin
        if (!advance) begin
          if (cmd_r == kmi_pkg::CMD_WRITE) begin
            state_nxt = (found || full || lock_block) ? kmi_pkg::S_RESP : kmi_pkg::S_ZERO;
          end else begin
            state_nxt = div_req.start ? kmi_pkg::S_DIV : kmi_pkg::S_RD;
          end
        end
      end
      kmi_pkg::S_DIV:  if (div_rsp.done) state_nxt = kmi_pkg::S_RD;
      kmi_pkg::S_ZERO: if (z_r == EW'(kmi_pkg::ELEMS - 1)) state_nxt = kmi_pkg::S_RESP;
      kmi_pkg::S_RESP: if (out_free) state_nxt = kmi_pkg::S_IDLE;
      kmi_pkg::S_RD:   state_nxt = kmi_pkg::S_MUL;
      kmi_pkg::S_MUL:  state_nxt = kmi_pkg::S_EMIT;
      kmi_pkg::S_EMIT: begin
        if (out_free) begin
          state_nxt = (e_r == EW'(kmi_pkg::ELEMS - 1)) ? kmi_pkg::S_IDLE : kmi_pkg::S_RD;
        end
      end
      default: state_nxt = kmi_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= kmi_pkg::S_IDLE;
      key_cnt_r <= '0;
      lock_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        lock_r <= cfg_single_key_lock;
      end
      if (in_acc && (kmi_pkg::cmd_t'(in_command) == kmi_pkg::CMD_CLEAR)) begin
        key_cnt_r <= '0;
      end else if ((state_r == kmi_pkg::S_ZERO) && (z_r == EW'(kmi_pkg::ELEMS - 1))) begin
        key_cnt_r <= key_cnt_r + CW'(1);
      end
    end
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= kmi_pkg::cmd_t'(in_command);
      t_r      <= in_key_time;
      ei_r     <= in_element_index;
      ev_r     <= in_element_value;
      pos_r    <= '0;
      status_r <= kmi_pkg::ST_OK;
    end
    unique case (state_r)
      kmi_pkg::S_SRCH: begin
        if (advance) begin
          prev_time_r <= cur_time;
          prev_slot_r <= cur_slot;
          pos_r       <= pos_r + CW'(1);
        end else if (cmd_r == kmi_pkg::CMD_WRITE) begin
          if (found) begin
            nonid_r[cur_slot][ei_r] <= ev_r != kmi_pkg::ident_val(ei_r);
          end else if (full) begin
            status_r <= kmi_pkg::ST_FULL;
          end else if (lock_block) begin
            status_r <= kmi_pkg::ST_LOCKED;
          end else begin
            for (int i = 1; i < MK; i++) begin
              if (CW'(i) > pos_r) begin
                times_r[i] <= times_r[i-1];
                slots_r[i] <= slots_r[i-1];
              end
            end
            times_r[pos_idx] <= t_r;
            slots_r[pos_idx] <= new_slot;
            for (int e = 0; e < kmi_pkg::ELEMS; e++) begin
              nonid_r[new_slot][e] <= (EW'(e) == ei_r) ?
                                      (ev_r != kmi_pkg::ident_val(ei_r)) :
                                      kmi_pkg::is_diag(EW'(e));
            end
            z_r <= '0;
          end
        end else begin
          slot_a_r <= (pos_r == '0) ? cur_slot : prev_slot_r;
          slot_b_r <= blend_case ? cur_slot : ((pos_r == '0) ? cur_slot : prev_slot_r);
          alpha_r  <= '0;
          e_r      <= '0;
        end
      end
      kmi_pkg::S_DIV:  if (div_rsp.done) alpha_r <= div_rsp.alpha;
      kmi_pkg::S_ZERO: z_r <= z_r + EW'(1);
      kmi_pkg::S_EMIT: if (out_free) e_r <= e_r + EW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_emit || load_resp) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_emit) begin
      out_value_r  <= (key_cnt_r == '0) ? kmi_pkg::ident_val(e_r) : blend_value;
      out_index_r  <= e_r;
      out_last_r   <= e_r == EW'(kmi_pkg::ELEMS - 1);
      out_status_r <= kmi_pkg::ST_OK;
      out_anim_r   <= anim_now;
      out_ident_r  <= ident_now;
    end else if (load_resp) begin
      out_value_r  <= '0;
      out_index_r  <= (cmd_r == kmi_pkg::CMD_CLEAR) ? '0 : ei_r;
      out_last_r   <= 1'b1;
      out_status_r <= status_r;
      out_anim_r   <= anim_now;
      out_ident_r  <= ident_now;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_result_value     = out_value_r;
  assign out_result_index     = out_index_r;
  assign out_last_of_run      = out_last_r;
  assign out_status           = out_status_r;
  assign out_is_animated_flag = out_anim_r;
  assign out_is_identity_flag = out_ident_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall || (cmd_r == kmi_pkg::CMD_NONE))
    else $error("block took an item but did not go busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    key_cnt_r <= CW'(MK))
    else $error("key count beyond table size");

  a_read_then_mul: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == kmi_pkg::S_RD |=> state_r == kmi_pkg::S_MUL)
    else $error("element pipeline skipped its multiply step");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != kmi_pkg::ST_OK) |-> out_last_r && (out_value_r == '0))
    else $error("rejected write carries data");

  a_div_only_query: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (den_full[TW-1:0] != '0) && (num_full[TW-1:0] <= den_full[TW-1:0]))
    else $error("blend weight out of range");

endmodule

>>> design/kmi_alpha_div.sv
// Restoring divider that forms the blend weight one quotient bit per cycle.
module kmi_alpha_div (
  input  logic              clk,
  input  logic              rst_n,
  input  kmi_pkg::div_req_t req,
  output kmi_pkg::div_rsp_t rsp
);

  logic [kmi_pkg::DIFF_W-1:0]  rem_r;
  logic [kmi_pkg::TIME_W-1:0]  den_r;
  logic [kmi_pkg::ALPHA_W-1:0] q_r;
  logic [4:0]                  cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic                        ge;
  logic [kmi_pkg::DIFF_W-1:0]  rem_sub;

  assign ge      = rem_r >= {1'b0, den_r};
  assign rem_sub = ge ? rem_r - {1'b0, den_r} : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(kmi_pkg::ALPHA_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The numerator never exceeds the divisor, so the first bit needs no shift.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= {1'b0, req.num};
      den_r <= req.den;
      q_r   <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[kmi_pkg::ALPHA_W-2:0], ge};
      rem_r <= {rem_sub[kmi_pkg::DIFF_W-2:0], 1'b0};
    end
  end

  assign rsp.done  = done_r;
  assign rsp.alpha = q_r;

endmodule

>>> design/kmi_matrix_store.sv
// Keyframe element memory with two read ports and the shared blend multiplier.
module kmi_matrix_store (
  input  logic                         clk,
  input  kmi_pkg::mem_wr_t             wr,
  input  logic [kmi_pkg::MADDR_W-1:0]  raddr_a,
  input  logic [kmi_pkg::MADDR_W-1:0]  raddr_b,
  input  logic [kmi_pkg::ALPHA_W-1:0]  alpha,
  output logic [kmi_pkg::VAL_W-1:0]    blend_value
);

  localparam int DEPTH = 1 << kmi_pkg::MADDR_W;
  localparam int PROD_W = kmi_pkg::VAL_W + 1 + kmi_pkg::ALPHA_W + 1;

  logic [kmi_pkg::VAL_W-1:0] mem [DEPTH];
  logic signed [kmi_pkg::VAL_W-1:0] rd_a_r;
  logic signed [kmi_pkg::VAL_W-1:0] rd_b_r;
  logic signed [kmi_pkg::VAL_W-1:0] base_r;
  logic signed [PROD_W-1:0]         prod_r;
  logic signed [kmi_pkg::VAL_W:0]   diff;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_a_r <= mem[raddr_a];
    rd_b_r <= mem[raddr_b];
  end

  // a + floor((b - a) * alpha / 2^16) equals the weighted sum floored.
  assign diff = {rd_b_r[kmi_pkg::VAL_W-1], rd_b_r} - {rd_a_r[kmi_pkg::VAL_W-1], rd_a_r};

  always_ff @(posedge clk) begin
    base_r <= rd_a_r;
    prod_r <= PROD_W'(diff * $signed({1'b0, alpha}));
  end

  assign blend_value = base_r + prod_r[kmi_pkg::VAL_W+15:16];

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the keyframe matrix interpolator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] ONE = 32'h0001_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_command = kmi_pkg::CMD_CLEAR;
  logic signed [23:0] in_key_time = '0;
  logic [3:0] in_element_index = '0;
  logic signed [31:0] in_element_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_result_value;
  logic [3:0] out_result_index;
  logic out_last_of_run;
  logic [1:0] out_status;
  logic out_is_animated_flag;
  logic out_is_identity_flag;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_single_key_lock = 1'b0;

  keyframe_matrix_interpolator u_top (.*);

  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  index;
    logic        last;
    logic [1:0]  status;
    logic        animated;
    logic        identity;
  } elem_result_t;

  typedef struct {
    kmi_pkg::cmd_t cmd;
    logic [23:0] t;
    logic [3:0]  ei;
    logic [31:0] ev;
    bit          fixed;
    logic [1:0]  want_status;
  } stim_row_t;

  // Predictor state.
  logic signed [23:0] kf_time [kmi_pkg::MAX_KEYS];
  logic signed [31:0] kf_mat  [kmi_pkg::MAX_KEYS][16];
  int kf_count;
  bit lock_mode;

  elem_result_t pending_results[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Timeout at %0t", $time);
    $display("Regression FAIL");
    $finish;
  end

  function automatic bit table_is_identity();
    for (int k = 0; k < kf_count; k++)
      for (int e = 0; e < 16; e++)
        if (kf_mat[k][e] != ((e % 5 == 0) ? ONE : 32'd0)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [31:0] mix_elems(logic signed [31:0] a, logic signed [31:0] b,
                                            longint alpha);
    longint s;
    s = longint'(a) * (65536 - alpha) + longint'(b) * alpha;
    if (s >= 0) return 32'(s >>> 16);
    return 32'(-((-s + 65535) >>> 16));
  endfunction

  function automatic void push_result(logic [31:0] v, logic [3:0] idx, bit last,
                                      logic [1:0] st);
    elem_result_t r;
    r.value = v;
    r.index = idx;
    r.last = last;
    r.status = st;
    r.animated = kf_count > 1;
    r.identity = table_is_identity();
    pending_results.push_back(r);
  endfunction

  // Applies one item to the predictor and queues the results it causes.
  function automatic void predict_item(kmi_pkg::cmd_t cmd, logic signed [23:0] t,
                                       logic [3:0] ei, logic signed [31:0] ev);
    int pos;
    logic [1:0] st;
    longint num, den, alpha;
    logic [31:0] v;
    pos = 0;
    while (pos < kf_count && kf_time[pos] < t) pos++;
    case (cmd)
      kmi_pkg::CMD_CLEAR: begin
        kf_count = 0;
        push_result('0, '0, 1'b1, kmi_pkg::ST_OK);
      end
      kmi_pkg::CMD_WRITE: begin
        st = kmi_pkg::ST_OK;
        if (pos < kf_count && kf_time[pos] == t) begin
          kf_mat[pos][ei] = ev;
        end else if (kf_count >= kmi_pkg::MAX_KEYS) begin
          st = kmi_pkg::ST_FULL;
        end else if (lock_mode && kf_count >= 1) begin
          st = kmi_pkg::ST_LOCKED;
        end else begin
          for (int k = kf_count; k > pos; k--) begin
            kf_time[k] = kf_time[k-1];
            kf_mat[k] = kf_mat[k-1];
          end
          kf_time[pos] = t;
          for (int e = 0; e < 16; e++) kf_mat[pos][e] = '0;
          kf_mat[pos][ei] = ev;
          kf_count++;
        end
        push_result('0, ei, 1'b1, st);
      end
      kmi_pkg::CMD_QUERY: begin
        for (int e = 0; e < 16; e++) begin
          if (kf_count == 0) v = (e % 5 == 0) ? ONE : 32'd0;
          else if (kf_count == 1 || pos == 0) v = kf_mat[0][e];
          else if (pos >= kf_count) v = kf_mat[kf_count-1][e];
          else begin
            num = longint'(t) - longint'(kf_time[pos-1]);
            den = longint'(kf_time[pos]) - longint'(kf_time[pos-1]);
            alpha = (num * 65536) / den;
            v = mix_elems(kf_mat[pos-1][e], kf_mat[pos][e], alpha);
          end
          push_result(v, 4'(e), e == 15, kmi_pkg::ST_OK);
        end
      end
      default: ;
    endcase
  endfunction

  // A gap drops valid; with no gap the next item follows at once.
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_item(kmi_pkg::cmd_t cmd, logic [23:0] t, logic [3:0] ei,
                           logic [31:0] ev);
    in_command <= cmd;
    in_key_time <= t;
    in_element_index <= ei;
    in_element_value <= ev;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(cmd, t, ei, ev);
    n_items++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_lock(bit val);
    cfg_single_key_lock <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    lock_mode = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result checker.
  always @(posedge clk) begin
    elem_result_t got, exp_r;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_result_value, out_result_index, out_last_of_run, out_status,
             out_is_animated_flag, out_is_identity_flag};
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got !== exp_r) begin
          $display("%0t: mismatch expected val=%h idx=%0d last=%0b st=%0d anim=%0b id=%0b",
                   $time, exp_r.value, exp_r.index, exp_r.last, exp_r.status,
                   exp_r.animated, exp_r.identity);
          $display("%0t:          actual val=%h idx=%0d last=%0b st=%0d anim=%0b id=%0b",
                   $time, got.value, got.index, got.last, got.status,
                   got.animated, got.identity);
          errors++;
        end
      end
    end
  end

  // Receiver stalls at random, with calm stretches.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 5) == 0) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(20, 60)) @(negedge clk);
      end
    end
  end

  stim_row_t dir_rows[$];

  function automatic void add_row(kmi_pkg::cmd_t c, logic [23:0] t, logic [3:0] ei,
                                  logic [31:0] ev, bit fixed = 1'b0,
                                  logic [1:0] ws = kmi_pkg::ST_OK);
    stim_row_t r;
    r.cmd = c; r.t = t; r.ei = ei; r.ev = ev; r.fixed = fixed; r.want_status = ws;
    dir_rows.push_back(r);
  endfunction

  function automatic logic [23:0] rand_time(int ntimes);
    if (ntimes > 0) return 24'($urandom_range(0, ntimes - 1) * 24'h1_3000 - 24'h8_0000);
    return 24'($urandom);
  endfunction

  initial begin
    int kind, n_keys;
    logic [31:0] v;
    kf_count = 0;
    lock_mode = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: the query on an empty table must return identity.
    add_row(kmi_pkg::CMD_QUERY, 24'h00_0000, 4'd0, 32'd0, 1'b1);
    add_row(kmi_pkg::CMD_WRITE, 24'h80_0000, 4'd0, 32'h8000_0000, 1'b1, kmi_pkg::ST_OK);
    add_row(kmi_pkg::CMD_WRITE, 24'h7F_FFFF, 4'd15, 32'h7FFF_FFFF, 1'b1, kmi_pkg::ST_OK);
    add_row(kmi_pkg::CMD_QUERY, 24'h80_0000, 4'd0, 32'd0);
    add_row(kmi_pkg::CMD_QUERY, 24'h7F_FFFF, 4'd0, 32'd0);
    add_row(kmi_pkg::CMD_QUERY, 24'h00_0000, 4'd0, 32'd0);
    add_row(kmi_pkg::CMD_WRITE, 24'h00_0000, 4'd5, 32'h0001_8000, 1'b1, kmi_pkg::ST_OK);
    add_row(kmi_pkg::CMD_QUERY, 24'h00_0000, 4'd0, 32'd0);
    add_row(kmi_pkg::CMD_QUERY, 24'h40_0000, 4'd0, 32'd0);
    add_row(kmi_pkg::CMD_NONE, 24'h12_3456, 4'd3, 32'hDEAD_BEEF);
    add_row(kmi_pkg::CMD_CLEAR, 24'h0, 4'd0, 32'd0, 1'b1, kmi_pkg::ST_OK);
    add_row(kmi_pkg::CMD_QUERY, 24'hFF_FFFF, 4'd0, 32'd0);
    for (int k = 0; k < 17; k++) begin
      if (k < 16) add_row(kmi_pkg::CMD_WRITE, 24'(k * 24'h1_0000), 4'(k), ONE, 1'b1,
                          kmi_pkg::ST_OK);
      else add_row(kmi_pkg::CMD_WRITE, 24'h7F_0000, 4'd1, 32'h1, 1'b1, kmi_pkg::ST_FULL);
    end
    add_row(kmi_pkg::CMD_WRITE, 24'h03_0000, 4'd0, 32'hFFFF_0000, 1'b1, kmi_pkg::ST_OK);
    add_row(kmi_pkg::CMD_QUERY, 24'h02_8000, 4'd0, 32'd0);
    add_row(kmi_pkg::CMD_QUERY, 24'h03_0000, 4'd0, 32'd0);
    foreach (dir_rows[i]) begin
      idle_gap();
      send_item(dir_rows[i].cmd, dir_rows[i].t, dir_rows[i].ei, dir_rows[i].ev);
      if (dir_rows[i].fixed && pending_results.size() != 0 &&
          dir_rows[i].cmd != kmi_pkg::CMD_QUERY &&
          pending_results[$].status != dir_rows[i].want_status) begin
        $display("%0t: status row %0d expected %0d actual prediction %0d", $time, i,
                 dir_rows[i].want_status, pending_results[$].status);
        errors++;
      end
      if (i == 0) begin
        for (int e = 0; e < 16; e++)
          if (pending_results[e].value != ((e % 5 == 0) ? ONE : 32'd0)) begin
            $display("%0t: empty table element %0d expected %h actual prediction %h",
                     $time, e, ((e % 5 == 0) ? ONE : 32'd0), pending_results[e].value);
            errors++;
          end
      end
    end
    wait_drained();

    // Lock phase: only the existing key may be changed.
    write_lock(1'b1);
    send_item(kmi_pkg::CMD_WRITE, 24'h05_0000, 4'd2, 32'h5);
    send_item(kmi_pkg::CMD_CLEAR, '0, '0, '0);
    send_item(kmi_pkg::CMD_WRITE, 24'h05_0000, 4'd2, 32'h5);
    send_item(kmi_pkg::CMD_WRITE, 24'h06_0000, 4'd2, 32'h6);
    send_item(kmi_pkg::CMD_WRITE, 24'h05_0000, 4'd10, ONE);
    send_item(kmi_pkg::CMD_QUERY, 24'h09_0000, '0, '0);
    wait_drained();
    write_lock(1'b0);

    // Random part: build small tables with random content, then query them among stray writes and no-op items.
    while (n_items < 300) begin
      if (n_items > 230 && !lock_mode && $urandom_range(0, 1) == 0) begin
        wait_drained();
        write_lock(1'b1);
      end else if (lock_mode && $urandom_range(0, 3) == 0) begin
        wait_drained();
        write_lock(1'b0);
      end
      idle_gap();
      send_item(kmi_pkg::CMD_CLEAR, '0, '0, '0);
      n_keys = $urandom_range(1, 6);
      for (int j = 0; j < $urandom_range(2, 12); j++) begin
        kind = $urandom_range(0, 9);
        case (kind)
          0: v = $urandom;
          1: v = (kind & 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
          2: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
          default: v = 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
        endcase
        idle_gap();
        send_item(kmi_pkg::CMD_WRITE, rand_time(($urandom_range(0, 7) == 0) ? 0 : n_keys),
                  4'($urandom), v);
      end
      for (int j = 0; j < $urandom_range(1, 4); j++) begin
        idle_gap();
        kind = $urandom_range(0, 15);
        if (kind == 0) send_item(kmi_pkg::CMD_NONE, 24'($urandom), 4'($urandom), $urandom);
        else if (kind == 1) send_item(kmi_pkg::CMD_WRITE, 24'($urandom), 4'($urandom),
                                      $urandom);
        else send_item(kmi_pkg::CMD_QUERY, ($urandom_range(0, 3) == 0) ? 24'($urandom) :
                       24'($signed($urandom_range(0, 7 * 24'h1_3000)) - 24'h8_8000),
                       4'($urandom), $urandom);
      end
    end
    wait_drained();

    $display("Sent %0d items and checked %0d results over both lock settings.",
             n_items, n_results);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
